// ===== design/sat_pkg.sv =====
// Shared types, constants and helpers for the section address translator.
`default_nettype none

package sat_pkg;

  // Table depth and widths
  localparam int unsigned MAX_SECTIONS = 16;
  localparam int unsigned ADDR_W       = 32;
  localparam int unsigned IDX_W        = 4;
  localparam int unsigned COUNT_W      = 5;
  localparam int unsigned CFG_IDX_W    = 2;
  // Width for comparing slot numbers, counts and entry indexes (covers up to 255 cells)
  localparam int unsigned CMP_W        = 8;

  // Register reset values
  localparam logic [ADDR_W-1:0]  IMAGE_BASE_RST    = 32'h0040_0000;
  localparam logic [ADDR_W-1:0]  SECTION_ALIGN_RST = 32'h0000_1000;
  localparam logic [COUNT_W-1:0] SECTION_COUNT_RST = '0;

  // Operation codes carried by an input word
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_XLATE = 1'b1
  } op_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_BASE    = 2'd0,
    REG_SECTION_ALIGN = 2'd1,
    REG_SECTION_COUNT = 2'd2
  } reg_idx_t;

  // Word travelling down the cell chain
  typedef struct packed {
    logic              valid;
    op_t               op;
    logic [IDX_W-1:0]  idx;
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] size;
    logic [ADDR_W-1:0] raw;
    logic [ADDR_W-1:0] rel;
    logic              found;
    logic [ADDR_W-1:0] result;
  } item_t;

  // Round a region size up to the alignment, wrapping at 32 bits
  function automatic logic [ADDR_W-1:0] aligned_size(input logic [ADDR_W-1:0] size,
                                                     input logic [ADDR_W-1:0] align);
    logic [ADDR_W-1:0] m;
    m = align - 1'b1;
    if ((size & m) == '0) begin
      return size;
    end
    return (size & ~m) + align;
  endfunction

endpackage

`default_nettype wire

// ===== design/section_address_translator.sv =====
// Top level of the section address translator: input stage, cell chain and result port.
//
// Usage: an input word either writes one region entry (operation 0) or translates an
// address (operation 1). A word is taken when in_valid is high and in_stall is low.
// Each translate word yields one result word (out_file_offset, out_hit) on the out_
// channel, taken when out_valid is high and out_stall is low; a write word yields none.
// Configuration registers (0 image_base, 1 section_align, 2 section_count) are written
// on the cfg_ channel, which is always ready; write them only while the block is idle.
// A word passes the input stage register and one register in each of the MAX_SECTIONS
// = 16 table cells; its result is presented at the end of the chain.
// Throughput: one word per cycle while no result is stalled; words follow each other
// down the chain, and a write is seen by every translate that comes after it.
// Reset (rst_n low, synchronous) empties the chain and loads the register reset values;
// table entries hold nothing defined until written.
// When the receiver stalls a waiting result, the whole chain holds and in_stall rises;
// a write word that reaches the end drops out without waiting.
`default_nettype none

module section_address_translator
  import sat_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input channel
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_operation,
  input  wire logic [IDX_W-1:0]     in_entry_index,
  input  wire logic [ADDR_W-1:0]    in_region_start,
  input  wire logic [ADDR_W-1:0]    in_region_size,
  input  wire logic [ADDR_W-1:0]    in_region_raw,
  input  wire logic [ADDR_W-1:0]    in_address,
  // result channel
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [ADDR_W-1:0]         out_file_offset,
  output logic                      out_hit,
  // configuration channel
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ADDR_W-1:0]    cfg_data
);

  logic [ADDR_W-1:0]  image_base_r;
  logic [ADDR_W-1:0]  section_align_r;
  logic [COUNT_W-1:0] section_count_r;

  item_t              stage_r;
  item_t              stage_nxt;
  item_t              chain [MAX_SECTIONS+1];
  logic               advance;
  logic               accept;

  // Configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_base_r    <= IMAGE_BASE_RST;
      section_align_r <= SECTION_ALIGN_RST;
      section_count_r <= SECTION_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_IMAGE_BASE:    image_base_r    <= cfg_data;
        REG_SECTION_ALIGN: section_align_r <= cfg_data;
        REG_SECTION_COUNT: section_count_r <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold the chain while a result waits on a stalled receiver
  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;
  assign accept   = in_valid && advance;

  // Input stage: form the relative address
  always_comb begin
    stage_nxt        = '0;
    stage_nxt.valid  = accept;
    stage_nxt.op     = op_t'(in_operation);
    stage_nxt.idx    = in_entry_index;
    stage_nxt.start  = in_region_start;
    stage_nxt.size   = in_region_size;
    stage_nxt.raw    = in_region_raw;
    stage_nxt.rel    = in_address - image_base_r;
    stage_nxt.found  = 1'b0;
    stage_nxt.result = in_address - image_base_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else if (advance) begin
      stage_r <= stage_nxt;
    end
  end

  assign chain[0] = stage_r;

  // Row of table cells, one slot each
  for (genvar i = 0; i < MAX_SECTIONS; i++) begin : g_cell
    sat_cell u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .advance       (advance),
      .cell_idx      (CMP_W'(i)),
      .section_count (section_count_r),
      .section_align (section_align_r),
      .item_in       (chain[i]),
      .item_out      (chain[i+1])
    );
  end

  // Present translate results; drop write words at the end of the chain
  assign out_valid       = chain[MAX_SECTIONS].valid && (chain[MAX_SECTIONS].op == OP_XLATE);
  assign out_file_offset = chain[MAX_SECTIONS].result;
  assign out_hit         = chain[MAX_SECTIONS].found;

endmodule

`default_nettype wire

// ===== design/sat_cell.sv =====
// One table slot of the translator chain: holds a region and tests passing words against it.
`default_nettype none

module sat_cell
  import sat_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               advance,
  input  wire logic [CMP_W-1:0]   cell_idx,
  input  wire logic [COUNT_W-1:0] section_count,
  input  wire logic [ADDR_W-1:0]  section_align,
  input  wire item_t              item_in,
  output item_t                   item_out
);

  logic [ADDR_W-1:0] start_r;
  logic [ADDR_W-1:0] size_r;
  logic [ADDR_W-1:0] aligned_r;
  logic [ADDR_W-1:0] delta_r;
  item_t             item_r;
  item_t             item_nxt;

  logic              wr_hit;
  logic              active;
  logic [ADDR_W:0]   end_sum;
  logic              in_range;
  logic              take;

  // Decode a write aimed at this slot and whether the slot is searched
  assign wr_hit = item_in.valid && (item_in.op == OP_WRITE) &&
                  (CMP_W'(item_in.idx) == cell_idx);
  assign active = CMP_W'(section_count) > cell_idx;

  // Range test: a region whose end wraps never matches
  assign end_sum  = {1'b0, start_r} + {1'b0, aligned_r};
  assign in_range = (item_in.rel >= start_r) && !end_sum[ADDR_W] &&
                    (item_in.rel < end_sum[ADDR_W-1:0]);

  assign take = item_in.valid && (item_in.op == OP_XLATE) && !item_in.found &&
                active && in_range;

  // Claim the word on the first matching slot
  always_comb begin
    item_nxt = item_in;
    if (take) begin
      item_nxt.found  = 1'b1;
      item_nxt.result = item_in.rel + delta_r;
    end
  end

  // Load the region entry
  always_ff @(posedge clk) begin
    if (advance && wr_hit) begin
      start_r <= item_in.start;
      size_r  <= item_in.size;
      delta_r <= item_in.raw - item_in.start;
    end
  end

  // Keep the aligned size current with the entry and the alignment register
  always_ff @(posedge clk) begin
    if (advance && wr_hit) begin
      aligned_r <= aligned_size(item_in.size, section_align);
    end else begin
      aligned_r <= aligned_size(size_r, section_align);
    end
  end

  // Hand the word to the next slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.valid <= 1'b0;
    end else if (advance) begin
      item_r <= item_nxt;
    end
  end

  assign item_out = item_r;

endmodule

`default_nettype wire

// ===== design/sat_checker.sv =====
// Port-level checks for the section address translator and their binding.
`default_nettype none

module sat_checker
  import sat_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_stall,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire logic [ADDR_W-1:0]    out_file_offset,
  input wire logic                 out_hit
);

  // Reset empties the chain: no result right after it
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result presented straight after reset");

  // A blocked result must hold the input side
  a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> in_stall)
    else $error("input taken while a result is blocked");

  // The input side is only held for a blocked result
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a blocked result");

  // A blocked result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_file_offset) && $stable(out_hit)))
    else $error("blocked result changed");

endmodule

bind section_address_translator sat_checker u_sat_checker (.*);

`default_nettype wire
